>>> rtl/irmr_pkg.sv
// Package for the infrared motor remote frame builder.
// Holds sizes, command and status codes and the controller/datapath link types.
// Has no dependencies; every other file uses it.
package irmr_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int MAX_REPEATS  = 16;
  localparam int MAX_RESULTS  = 32;
  localparam int HALF_RESULTS = MAX_RESULTS / 2;

  localparam int CH_W  = $clog2(NUM_CHANNELS);
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  localparam int MODE_W   = 2;
  localparam int CHAN_W   = 8;
  localparam int LEVEL_W  = 8;
  localparam int REP_W    = 5;
  localparam int NIB_W    = 4;
  localparam int FRAME_W  = 16;
  localparam int STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_SEND   = 2'd0,
    MODE_CACHE  = 2'd1,
    MODE_RESEND = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAN  = 2'd1,
    ST_BAD_LEVEL = 2'd2
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;  // latch a request and update the cache
    logic emit;  // register the next result
  } irmr_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last;  // the next emitted result is the final one
  } irmr_stat_t;

endpackage

>>> rtl/irmr_if.sv
// Handshake channels of the frame builder: request input and result output.
// Depends on irmr_pkg for field widths.
interface irmr_in_if;
  logic                          valid;
  logic                          ready;
  logic [irmr_pkg::MODE_W-1:0]   mode;
  logic [irmr_pkg::CHAN_W-1:0]   channel;
  logic                          port_sel;
  logic [irmr_pkg::LEVEL_W-1:0]  level;
  logic                          tx_mode;
  logic [irmr_pkg::REP_W-1:0]    repeat_count;

  modport source (output valid, mode, channel, port_sel, level, tx_mode, repeat_count,
                  input ready);
  modport sink   (input valid, mode, channel, port_sel, level, tx_mode, repeat_count,
                  output ready);
endinterface

interface irmr_out_if;
  logic                           valid;
  logic                           ready;
  logic [irmr_pkg::FRAME_W-1:0]   frame;
  logic                           frame_valid;
  logic [irmr_pkg::STATUS_W-1:0]  status;
  logic [irmr_pkg::NIB_W-1:0]     cached_a;
  logic [irmr_pkg::NIB_W-1:0]     cached_b;
  logic                           cached_tx_mode;
  logic                           last;

  modport source (output valid, frame, frame_valid, status, cached_a, cached_b,
                  cached_tx_mode, last, input ready);
  modport sink   (input valid, frame, frame_valid, status, cached_a, cached_b,
                  cached_tx_mode, last, output ready);
endinterface

>>> rtl/irmr_ctrl.sv
// Controller of the frame builder: takes requests and paces result emission.
// Depends on irmr_pkg for the command and status structs.
module irmr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output irmr_pkg::irmr_cmd_t  cmd,
  input  irmr_pkg::irmr_stat_t stat
);

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load      = 1'b0;
    cmd.emit      = 1'b0;
    state_nxt     = state_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          if (stat.last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/irmr_datapath.sv
// Datapath of the frame builder: channel cache, request registers, frame
// assembly and the result register. Depends on irmr_pkg.
module irmr_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  irmr_pkg::irmr_cmd_t              cmd,
  output irmr_pkg::irmr_stat_t             stat,
  input  logic [irmr_pkg::MODE_W-1:0]      in_mode,
  input  logic [irmr_pkg::CHAN_W-1:0]      in_channel,
  input  logic                             in_port_sel,
  input  logic [irmr_pkg::LEVEL_W-1:0]     in_level,
  input  logic                             in_tx_mode,
  input  logic [irmr_pkg::REP_W-1:0]       in_repeat_count,
  output logic [irmr_pkg::FRAME_W-1:0]     out_frame,
  output logic                             out_frame_valid,
  output logic [irmr_pkg::STATUS_W-1:0]    out_status,
  output logic [irmr_pkg::NIB_W-1:0]       out_cached_a,
  output logic [irmr_pkg::NIB_W-1:0]       out_cached_b,
  output logic                             out_cached_tx_mode,
  output logic                             out_last
);

  localparam int CH_W  = irmr_pkg::CH_W;
  localparam int CNT_W = irmr_pkg::CNT_W;
  localparam int NIB_W = irmr_pkg::NIB_W;

  // Per-channel cache.
  logic [NIB_W-1:0] level_a_r [irmr_pkg::NUM_CHANNELS];
  logic [NIB_W-1:0] level_b_r [irmr_pkg::NUM_CHANNELS];
  logic             tx_mode_r [irmr_pkg::NUM_CHANNELS];
  logic             toggle_r  [irmr_pkg::NUM_CHANNELS];

  // Latched request.
  logic [CH_W-1:0]               idx_r;
  logic                          chan_ok_r;
  logic                          single_r;
  logic                          resend_r;
  logic                          port_r;
  logic                          alt_r;
  logic [CNT_W-1:0]              rem_r;
  irmr_pkg::status_t             status_r;

  // Result register.
  logic [irmr_pkg::FRAME_W-1:0]  frame_r;
  logic                          frame_valid_r;
  logic [irmr_pkg::STATUS_W-1:0] res_status_r;
  logic [NIB_W-1:0]              cached_a_r;
  logic [NIB_W-1:0]              cached_b_r;
  logic                          cached_tx_r;
  logic                          last_r;

  // Request decode.
  irmr_pkg::mode_t   mode_in;
  logic              chan_ok;
  logic [CH_W-1:0]   idx_in;
  logic              level_ok;
  logic              write_en;
  logic [CNT_W-1:0]  reps;
  logic [CNT_W-1:0]  reps_full;
  logic [CNT_W-1:0]  reps_half;
  logic [CNT_W-1:0]  count_nxt;
  irmr_pkg::status_t status_nxt;
  logic              single_nxt;

  // Frame assembly.
  logic              emit_port;
  logic              toggle_new;
  logic [NIB_W-1:0]  n1, n2, n3, chk;
  logic [NIB_W-1:0]  emit_level;
  logic              has_frame;

  assign mode_in  = irmr_pkg::mode_t'(in_mode);
  assign chan_ok  = (in_channel >= irmr_pkg::CHAN_W'(1)) &&
                    (in_channel <= irmr_pkg::CHAN_W'(irmr_pkg::NUM_CHANNELS));
  assign idx_in   = chan_ok ? CH_W'(in_channel - irmr_pkg::CHAN_W'(1)) : '0;
  assign level_ok = (in_level[irmr_pkg::LEVEL_W-1:NIB_W] == '0);

  always_comb begin
    if (CNT_W'(in_repeat_count) > CNT_W'(irmr_pkg::MAX_REPEATS))
      reps = CNT_W'(irmr_pkg::MAX_REPEATS);
    else
      reps = CNT_W'(in_repeat_count);
    reps_full = (reps > CNT_W'(irmr_pkg::MAX_RESULTS)) ? CNT_W'(irmr_pkg::MAX_RESULTS) : reps;
    reps_half = (reps > CNT_W'(irmr_pkg::HALF_RESULTS)) ?
                CNT_W'(irmr_pkg::HALF_RESULTS) : reps;
  end

  always_comb begin
    status_nxt = irmr_pkg::ST_OK;
    count_nxt  = '0;
    write_en   = 1'b0;
    single_nxt = in_tx_mode;
    unique case (mode_in) inside
      irmr_pkg::MODE_SEND, irmr_pkg::MODE_CACHE: begin
        if (!chan_ok) begin
          status_nxt = irmr_pkg::ST_BAD_CHAN;
        end else if (!level_ok) begin
          status_nxt = irmr_pkg::ST_BAD_LEVEL;
        end else begin
          write_en = 1'b1;
          if (mode_in == irmr_pkg::MODE_SEND) count_nxt = reps_full;
        end
      end
      irmr_pkg::MODE_RESEND: begin
        single_nxt = tx_mode_r[idx_in];
        if (!chan_ok) begin
          status_nxt = irmr_pkg::ST_BAD_CHAN;
        end else if (tx_mode_r[idx_in]) begin
          // Each repetition sends a port A frame and a port B frame.
          count_nxt = CNT_W'({reps_half, 1'b0});
        end else begin
          count_nxt = reps_full;
        end
      end
      irmr_pkg::MODE_UNUSED: status_nxt = irmr_pkg::ST_OK;
      default: status_nxt = irmr_pkg::ST_OK;
    endcase
  end

  assign has_frame  = (rem_r != '0);
  assign emit_port  = resend_r ? alt_r : port_r;
  assign toggle_new = ~toggle_r[idx_r];
  assign emit_level = emit_port ? level_b_r[idx_r] : level_a_r[idx_r];

  always_comb begin
    if (single_r) begin
      n1 = {toggle_new, 1'b0, idx_r};
      n2 = {3'b010, emit_port};
      n3 = emit_level;
    end else begin
      n1 = {2'b01, idx_r};
      n2 = level_b_r[idx_r];
      n3 = level_a_r[idx_r];
    end
    chk = 4'hF ^ n1 ^ n2 ^ n3;
  end

  assign stat.last = (rem_r <= CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < irmr_pkg::NUM_CHANNELS; i++) begin
        level_a_r[i] <= '0;
        level_b_r[i] <= '0;
        tx_mode_r[i] <= 1'b0;
        toggle_r[i]  <= 1'b0;
      end
      rem_r <= '0;
    end else begin
      if (cmd.load) begin
        if (write_en) begin
          if (in_port_sel) level_b_r[idx_in] <= in_level[NIB_W-1:0];
          else             level_a_r[idx_in] <= in_level[NIB_W-1:0];
          tx_mode_r[idx_in] <= in_tx_mode;
        end
        rem_r <= count_nxt;
      end else if (cmd.emit && has_frame) begin
        rem_r <= rem_r - CNT_W'(1);
        if (single_r) toggle_r[idx_r] <= toggle_new;
      end
    end
  end

  // Request and result payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r     <= idx_in;
      chan_ok_r <= chan_ok;
      single_r  <= single_nxt;
      resend_r  <= (mode_in == irmr_pkg::MODE_RESEND);
      port_r    <= in_port_sel;
      alt_r     <= 1'b0;
      status_r  <= status_nxt;
    end else if (cmd.emit && has_frame) begin
      alt_r <= ~alt_r;
    end
    if (cmd.emit) begin
      frame_r       <= has_frame ? {n1, n2, n3, chk} : '0;
      frame_valid_r <= has_frame;
      res_status_r  <= status_r;
      cached_a_r    <= chan_ok_r ? level_a_r[idx_r] : '0;
      cached_b_r    <= chan_ok_r ? level_b_r[idx_r] : '0;
      cached_tx_r   <= chan_ok_r ? tx_mode_r[idx_r] : 1'b0;
      last_r        <= stat.last;
    end
  end

  assign out_frame          = frame_r;
  assign out_frame_valid    = frame_valid_r;
  assign out_status         = res_status_r;
  assign out_cached_a       = cached_a_r;
  assign out_cached_b       = cached_b_r;
  assign out_cached_tx_mode = cached_tx_r;
  assign out_last           = last_r;

endmodule

>>> rtl/ir_motor_remote_frame_builder_unit.sv
// Infrared motor remote frame builder, top level. The first result is registered
// in S_EMIT, once the output slot is free, after a request is taken. A request yielding
// n frames gives max(n,1) results, one per cycle while the sink is ready, and keeps
// in_ready low until the final result is registered.
// Synchronous active-low reset clears the channel cache and the controller.
module ir_motor_remote_frame_builder_unit (
  input logic       clk,
  input logic       rst_n,
  irmr_in_if.sink   in_chan,
  irmr_out_if.source out_chan
);

  irmr_pkg::irmr_cmd_t  cmd;
  irmr_pkg::irmr_stat_t stat;

  irmr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  irmr_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_mode            (in_chan.mode),
    .in_channel         (in_chan.channel),
    .in_port_sel        (in_chan.port_sel),
    .in_level           (in_chan.level),
    .in_tx_mode         (in_chan.tx_mode),
    .in_repeat_count    (in_chan.repeat_count),
    .out_frame          (out_chan.frame),
    .out_frame_valid    (out_chan.frame_valid),
    .out_status         (out_chan.status),
    .out_cached_a       (out_chan.cached_a),
    .out_cached_b       (out_chan.cached_b),
    .out_cached_tx_mode (out_chan.cached_tx_mode),
    .out_last           (out_chan.last)
  );

endmodule
